[design/cud_pkg.sv]
package cud_pkg;

  typedef enum logic [3:0] {
    PH_PREFIX  = 4'b0001,
    PH_SIZE    = 4'b0010,
    PH_CHUNK   = 4'b0100,
    PH_STOPPED = 4'b1000
  } cud_phase_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EOF     = 2'd1,
    KIND_ERROR   = 2'd2
  } cud_kind_t;

  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_PREFIX = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PREFIX = 8'd1;

  localparam logic [7:0] MIN_PREFIX_RESET = 8'd3;
  localparam logic [7:0] MAX_PREFIX_RESET = 8'd42;

  typedef struct packed {
    cud_kind_t  kind;
    logic [7:0] payload;
    logic [7:0] prefix_value;
    logic       chunk_last;
  } cud_result_t;

endpackage

[design/cud_in_if.sv]
interface cud_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

[design/cud_out_if.sv]
interface cud_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] payload;
  logic [7:0] prefix_value;
  logic       chunk_last;

  modport source (output valid, output kind, output payload, output prefix_value,
                  output chunk_last, input ready);
  modport sink (input valid, input kind, input payload, input prefix_value,
                input chunk_last, output ready);
endinterface

[design/cud_cfg_if.sv]
interface cud_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[design/cud_parser.sv]
module cud_parser #(
  parameter int unsigned SIZE_FIELD_BYTES = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  logic [7:0]          data_byte,
  input  logic [7:0]          min_prefix,
  input  logic [7:0]          max_prefix,
  output logic                res_valid,
  output cud_pkg::cud_result_t res
);
  import cud_pkg::*;

  localparam int unsigned REM_W = 8 * SIZE_FIELD_BYTES;
  localparam int unsigned CNT_W = $clog2(SIZE_FIELD_BYTES);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SIZE_FIELD_BYTES - 1);

  cud_phase_t       phase_r, phase_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [7:0]       held_r, held_nxt;
  logic [REM_W-1:0] rem_asm;
  logic             chunk_end;

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    held_nxt  = held_r;
    res_valid = 1'b0;
    res       = '0;
    rem_asm   = (cnt_r == '0) ? {{(REM_W-8){1'b0}}, data_byte}
                              : {rem_r[REM_W-9:0], data_byte};
    chunk_end = (rem_r == REM_W'(1));
    case (phase_r)
      PH_PREFIX: begin
        held_nxt = data_byte;
        if ((data_byte < min_prefix) || (data_byte > max_prefix)) begin
          phase_nxt        = PH_STOPPED;
          res_valid        = 1'b1;
          res.kind         = KIND_ERROR;
          res.prefix_value = data_byte;
        end else begin
          phase_nxt = PH_SIZE;
          cnt_nxt   = '0;
          rem_nxt   = '0;
        end
      end
      PH_SIZE: begin
        rem_nxt = rem_asm;
        if (cnt_r == LAST_CNT) begin
          cnt_nxt = '0;
          if (rem_asm == '0) begin
            phase_nxt        = PH_PREFIX;
            res_valid        = 1'b1;
            res.kind         = KIND_EOF;
            res.prefix_value = held_r;
          end else begin
            phase_nxt = PH_CHUNK;
          end
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      PH_CHUNK: begin
        rem_nxt = rem_r - 1'b1;
        if (chunk_end) begin
          phase_nxt = PH_SIZE;
          cnt_nxt   = '0;
        end
        res_valid      = 1'b1;
        res.kind       = KIND_PAYLOAD;
        res.payload    = data_byte;
        res.chunk_last = chunk_end;
      end
      PH_STOPPED: begin
        phase_nxt = PH_STOPPED;
      end
      default: begin
        phase_nxt = PH_PREFIX;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_PREFIX;
      cnt_r   <= '0;
      rem_r   <= '0;
      held_r  <= '0;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      rem_r   <= rem_nxt;
      held_r  <= held_nxt;
    end
  end

endmodule

[design/chunked_upload_deframer_unit.sv]
// Output: a result appears on the output in the cycle after the word that causes it.
// Throughput: one word per cycle; a new word is taken while a result waits,
// as long as the output register is empty or being emptied in the same cycle.
// Reset: synchronous, active low; parser returns to expecting a prefix byte and the
// prefix limits return to 3 and 42.
module chunked_upload_deframer_unit #(
  parameter int unsigned SIZE_FIELD_BYTES = 4
) (
  input  logic  clk,
  input  logic  rst_n,
  cud_in_if.sink     in_if,
  cud_out_if.source  out_if,
  cud_cfg_if.sink    cfg_if
);
  import cud_pkg::*;

  logic        in_fire;
  logic        res_valid;
  cud_result_t res;
  logic        out_valid_r;
  cud_result_t out_r;
  logic [7:0]  min_prefix_r;
  logic [7:0]  max_prefix_r;

  assign in_if.ready = !out_valid_r || out_if.ready;
  assign in_fire     = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_prefix_r <= MIN_PREFIX_RESET;
      max_prefix_r <= MAX_PREFIX_RESET;
    end else if (cfg_if.valid) begin
      if (cfg_if.index == REG_MIN_PREFIX) begin
        min_prefix_r <= cfg_if.data;
      end else if (cfg_if.index == REG_MAX_PREFIX) begin
        max_prefix_r <= cfg_if.data;
      end
    end
  end

  cud_parser #(
    .SIZE_FIELD_BYTES(SIZE_FIELD_BYTES)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .data_byte  (in_if.data_byte),
    .min_prefix (min_prefix_r),
    .max_prefix (max_prefix_r),
    .res_valid  (res_valid),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= res_valid;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res_valid) begin
      out_r <= res;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.kind         = out_r.kind;
  assign out_if.payload      = out_r.payload;
  assign out_if.prefix_value = out_r.prefix_value;
  assign out_if.chunk_last   = out_r.chunk_last;

endmodule

[design/cud_checker.sv]
module cud_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_kind,
  input logic [7:0] out_payload,
  input logic [7:0] out_prefix_value,
  input logic       out_chunk_last
);
  import cud_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_kind_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_kind == KIND_PAYLOAD && out_prefix_value == 8'd0) ||
                  ((out_kind == KIND_EOF || out_kind == KIND_ERROR) &&
                   out_payload == 8'd0 && out_chunk_last == 1'b0))
    else $error("result fields inconsistent with kind");

  a_stop_after_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_kind == KIND_ERROR |=> !out_valid)
    else $error("result after prefix error");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !$past(out_valid) |-> $past(in_valid && in_ready))
    else $error("result without an accepted word");

endmodule

bind chunked_upload_deframer_unit cud_checker u_cud_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_if.valid),
  .in_ready         (in_if.ready),
  .out_valid        (out_if.valid),
  .out_ready        (out_if.ready),
  .out_kind         (out_if.kind),
  .out_payload      (out_if.payload),
  .out_prefix_value (out_if.prefix_value),
  .out_chunk_last   (out_if.chunk_last)
);

[tb/tb_chunked_upload_deframer_unit.sv]
module tb_chunked_upload_deframer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import cud_pkg::*;

  localparam int ITEM_TARGET = 1150;
  localparam int SIZE_BYTES = 4;
  localparam int IDLE_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 4;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'd9;
  localparam cud_result_t NO_RES = '0;

  typedef enum logic {ROW_BYTE, ROW_CFG} row_op_t;

  typedef struct packed {
    row_op_t     op;
    logic [7:0]  a;
    logic [7:0]  b;
    logic        typed;
    cud_result_t res;
  } row_t;

  localparam row_t DIRECTED_ROWS [29] = '{
    '{ROW_BYTE, 8'h03, 8'h00, 1'b0, NO_RES},
    '{ROW_BYTE, 8'h00, 8'h00, 1'b0, NO_RES},
    '{ROW_BYTE, 8'h00, 8'h00, 1'b0, NO_RES},
    '{ROW_BYTE, 8'h00, 8'h00, 1'b0, NO_RES},
    '{ROW_BYTE, 8'h02, 8'h00, 1'b0, NO_RES},
    '{ROW_BYTE, 8'hFF, 8'h00, 1'b1, '{KIND_PAYLOAD, 8'hFF, 8'h00, 1'b0}},
    '{ROW_BYTE, 8'h00, 8'h00, 1'b1, '{KIND_PAYLOAD, 8'h00, 8'h00, 1'b1}},
    '{ROW_BYTE, 8'h00, 8'h00, 1'b0, NO_RES},
    '{ROW_BYTE, 8'h00, 8'h00, 1'b0, NO_RES},
    '{ROW_BYTE, 8'h00, 8'h00, 1'b0, NO_RES},
    '{ROW_BYTE, 8'h00, 8'h00, 1'b1, '{KIND_EOF, 8'h00, 8'h03, 1'b0}},
    '{ROW_BYTE, 8'h2A, 8'h00, 1'b0, NO_RES},
    '{ROW_BYTE, 8'h00, 8'h00, 1'b0, NO_RES},
    '{ROW_BYTE, 8'h00, 8'h00, 1'b0, NO_RES},
    '{ROW_BYTE, 8'h00, 8'h00, 1'b0, NO_RES},
    '{ROW_BYTE, 8'h01, 8'h00, 1'b0, NO_RES},
    '{ROW_BYTE, 8'h5A, 8'h00, 1'b1, '{KIND_PAYLOAD, 8'h5A, 8'h00, 1'b1}},
    '{ROW_BYTE, 8'h00, 8'h00, 1'b0, NO_RES},
    '{ROW_BYTE, 8'h00, 8'h00, 1'b0, NO_RES},
    '{ROW_BYTE, 8'h00, 8'h00, 1'b0, NO_RES},
    '{ROW_BYTE, 8'h00, 8'h00, 1'b1, '{KIND_EOF, 8'h00, 8'h2A, 1'b0}},
    '{ROW_CFG, REG_MIN_PREFIX, 8'h00, 1'b0, NO_RES},
    '{ROW_CFG, REG_MAX_PREFIX, 8'hFF, 1'b0, NO_RES},
    '{ROW_CFG, REG_UNUSED, 8'h4D, 1'b0, NO_RES},
    '{ROW_BYTE, 8'h00, 8'h00, 1'b0, NO_RES},
    '{ROW_BYTE, 8'h00, 8'h00, 1'b0, NO_RES},
    '{ROW_BYTE, 8'h00, 8'h00, 1'b0, NO_RES},
    '{ROW_BYTE, 8'h00, 8'h00, 1'b0, NO_RES},
    '{ROW_BYTE, 8'h00, 8'h00, 1'b1, '{KIND_EOF, 8'h00, 8'h00, 1'b0}}
  };

  logic clk = 1'b0;
  logic rst_n;

  cud_in_if  in_if ();
  cud_out_if out_if ();
  cud_cfg_if cfg_if ();

  chunked_upload_deframer_unit #(
    .SIZE_FIELD_BYTES(SIZE_BYTES)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if),
    .out_if(out_if),
    .cfg_if(cfg_if)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  cud_phase_t  parse_phase;
  logic [1:0]  size_count;
  logic [31:0] bytes_left;
  logic [7:0]  file_prefix;
  logic [7:0]  prefix_lo;
  logic [7:0]  prefix_hi;

  cud_result_t due_results[$];
  int mismatches = 0;
  int bytes_sent = 0;
  int files_sent = 0;
  int payload_seen = 0;
  int eof_seen = 0;
  int error_seen = 0;
  int idle_cycles = 0;
  bit send_calm = 1'b0;
  bit take_calm = 1'b0;

  function automatic int draw_wait(bit calm);
    return calm ? 0 : $urandom_range(0, 7);
  endfunction

  function automatic bit deframe_byte(input logic [7:0] b, output cud_result_t r);
    r = NO_RES;
    case (parse_phase)
      PH_PREFIX: begin
        file_prefix = b;
        if (b < prefix_lo || b > prefix_hi) begin
          parse_phase = PH_STOPPED;
          r.kind = KIND_ERROR;
          r.prefix_value = b;
          return 1'b1;
        end
        parse_phase = PH_SIZE;
        size_count = '0;
        bytes_left = '0;
        return 1'b0;
      end
      PH_SIZE: begin
        if (size_count == 2'd0) bytes_left = '0;
        bytes_left = {bytes_left[23:0], b};
        if (int'(size_count) + 1 >= SIZE_BYTES) begin
          size_count = '0;
          if (bytes_left == 32'd0) begin
            parse_phase = PH_PREFIX;
            r.kind = KIND_EOF;
            r.prefix_value = file_prefix;
            return 1'b1;
          end
          parse_phase = PH_CHUNK;
          return 1'b0;
        end
        size_count = size_count + 2'd1;
        return 1'b0;
      end
      PH_CHUNK: begin
        bytes_left = bytes_left - 32'd1;
        r.kind = KIND_PAYLOAD;
        r.payload = b;
        r.chunk_last = (bytes_left == 32'd0);
        if (r.chunk_last) begin
          parse_phase = PH_SIZE;
          size_count = '0;
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic send_byte(input logic [7:0] b, input bit typed, input cud_result_t typed_res);
    int gap;
    cud_result_t r;
    bit got;
    gap = draw_wait(send_calm);
    @(negedge clk);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data_byte <= b;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    got = deframe_byte(b, r);
    if (typed) due_results.push_back(typed_res);
    else if (got) due_results.push_back(r);
    bytes_sent++;
    if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    drain_results();
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= d;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    if (idx == REG_MIN_PREFIX) prefix_lo = d;
    else if (idx == REG_MAX_PREFIX) prefix_hi = d;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    int stall;
    cud_result_t want;
    out_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = draw_wait(take_calm);
      @(negedge clk);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_if.ready <= 1'b1;
      @(posedge clk);
      while (!out_if.valid) @(posedge clk);
      if (due_results.size() == 0) begin
        report_mismatch($sformatf("unexpected word kind %0d payload %02h prefix %02h",
                                  out_if.kind, out_if.payload, out_if.prefix_value));
      end else begin
        want = due_results.pop_front();
        if (out_if.kind !== want.kind)
          report_mismatch($sformatf("kind %0d, expected %0d", out_if.kind, want.kind));
        if (out_if.payload !== want.payload)
          report_mismatch($sformatf("payload %02h, expected %02h",
                                    out_if.payload, want.payload));
        if (out_if.prefix_value !== want.prefix_value)
          report_mismatch($sformatf("prefix_value %02h, expected %02h",
                                    out_if.prefix_value, want.prefix_value));
        if (out_if.chunk_last !== want.chunk_last)
          report_mismatch($sformatf("chunk_last %0b, expected %0b",
                                    out_if.chunk_last, want.chunk_last));
        case (want.kind)
          KIND_PAYLOAD: payload_seen++;
          KIND_EOF:     eof_seen++;
          default:      error_seen++;
        endcase
      end
      if ($urandom_range(0, 39) == 0) take_calm = !take_calm;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Stalled for %0d cycles with %0d words still due.",
               idle_cycles, due_results.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int setting;
    int phase_bytes;
    int chunks;
    int len;
    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] pfx;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.data_byte = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    parse_phase = PH_PREFIX;
    size_count = '0;
    bytes_left = '0;
    file_prefix = '0;
    prefix_lo = MIN_PREFIX_RESET;
    prefix_hi = MAX_PREFIX_RESET;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED_ROWS[i]) begin
      if (DIRECTED_ROWS[i].op == ROW_CFG) begin
        cfg_write(DIRECTED_ROWS[i].a, DIRECTED_ROWS[i].b);
      end else begin
        send_byte(DIRECTED_ROWS[i].a, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].res);
      end
    end

    setting = 0;
    while (bytes_sent < ITEM_TARGET) begin
      case (setting % 5)
        0: begin
          lo = 8'h00;
          hi = 8'hFF;
        end
        1: begin
          lo = 8'($urandom_range(0, 255));
          hi = lo;
        end
        2: begin
          lo = 8'($urandom_range(0, 200));
          hi = 8'($urandom_range(lo, 255));
        end
        3: begin
          lo = MIN_PREFIX_RESET;
          hi = MAX_PREFIX_RESET;
        end
        default: begin
          lo = 8'hFA;
          hi = 8'hFF;
        end
      endcase
      if ($urandom_range(0, 1) == 0) begin
        cfg_write(REG_MIN_PREFIX, lo);
        cfg_write(REG_MAX_PREFIX, hi);
      end else begin
        cfg_write(REG_MAX_PREFIX, hi);
        cfg_write(REG_MIN_PREFIX, lo);
      end
      phase_bytes = 0;
      while (phase_bytes < 200 && bytes_sent < ITEM_TARGET) begin
        case ($urandom_range(0, 3))
          0: pfx = prefix_lo;
          1: pfx = prefix_hi;
          default: pfx = 8'($urandom_range(prefix_lo, prefix_hi));
        endcase
        send_byte(pfx, 1'b0, NO_RES);
        chunks = $urandom_range(0, 3);
        repeat (chunks) begin
          len = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 300) : $urandom_range(1, 16);
          for (int k = SIZE_BYTES - 1; k >= 0; k--) begin
            send_byte(8'(len >> (8 * k)), 1'b0, NO_RES);
          end
          repeat (len) send_byte(8'($urandom_range(0, 255)), 1'b0, NO_RES);
          phase_bytes += len + SIZE_BYTES;
        end
        repeat (SIZE_BYTES) send_byte(8'h00, 1'b0, NO_RES);
        phase_bytes += 1 + SIZE_BYTES;
        files_sent++;
        if ($urandom_range(0, 29) == 0) drain_results();
      end
      setting++;
    end

    // An empty prefix range rejects any prefix and leaves the parser stopped for good.
    cfg_write(REG_MIN_PREFIX, 8'hC8);
    cfg_write(REG_MAX_PREFIX, 8'h0A);
    send_byte(8'h64, 1'b1, '{KIND_ERROR, 8'h00, 8'h64, 1'b0});
    drain_results();
    repeat (8) @(posedge clk);

    $display("Sent %0d bytes in %0d random files across %0d prefix ranges.",
             bytes_sent, files_sent, setting);
    $display("Checked %0d payload, %0d end-of-file and %0d error words.",
             payload_seen, eof_seen, error_seen);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[chunked_upload_deframer_unit.f]
design/cud_pkg.sv
design/cud_in_if.sv
design/cud_out_if.sv
design/cud_cfg_if.sv
design/cud_parser.sv
design/chunked_upload_deframer_unit.sv
design/cud_checker.sv
tb/tb_chunked_upload_deframer_unit.sv
